// ----- design/rag_pkg.sv -----
// ----------------------------------------------------------------------------
// rag_pkg
// Shared widths, codes and types of the rational accumulator with gcd
// reduction.
// ----------------------------------------------------------------------------
`default_nettype none

package rag_pkg;

	// range of a stored fraction
	localparam int WORD_BITS = 32;

	// word field widths
	localparam int CMD_W  = 2;
	localparam int NUM_W  = 32;
	localparam int DEN_W  = 31;
	localparam int STAT_W = 2;

	// magnitudes and exact products
	localparam int MAG_W  = 32;
	localparam int PROD_W = 2 * MAG_W;

	// divider step counter
	localparam int DIV_CNT_W = $clog2(PROD_W);

	// 2^(WORD_BITS-1): bound of the magnitude of a stored numerator
	localparam logic [PROD_W-1:0] LIM = {{(PROD_W-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_MUL  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADDEN = 2'd1,
		ST_OVF    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_X,
		S_MUL_Y,
		S_MUL_Z,
		S_MUL_W,
		S_SUM,
		S_COMMIT,
		S_GCD,
		S_GCD_WAIT,
		S_RED_N,
		S_RED_D,
		S_CHECK,
		S_OUT
	} state_t;

	// request to the shared divider
	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [PROD_W-1:0] divisor;
	} div_req_t;

	// answer of the shared divider
	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
		logic [PROD_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- design/rag_if.sv -----
// ----------------------------------------------------------------------------
// rag_req_if / rag_rsp_if
// Valid/ready channels that carry command words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rag_req_if;
	logic                              valid;
	logic                              ready;
	logic [rag_pkg::CMD_W-1:0]         cmd;
	logic signed [rag_pkg::NUM_W-1:0]  operand_num;
	logic signed [rag_pkg::NUM_W-1:0]  operand_den;

	modport source (output valid, output cmd, output operand_num, output operand_den,
		input ready);
	modport sink (input valid, input cmd, input operand_num, input operand_den,
		output ready);
endinterface

interface rag_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [rag_pkg::NUM_W-1:0]  result_num;
	logic [rag_pkg::DEN_W-1:0]         result_den;
	logic [rag_pkg::STAT_W-1:0]        status;

	modport source (output valid, output result_num, output result_den, output status,
		input ready);
	modport sink (input valid, input result_num, input result_den, input status,
		output ready);
endinterface

`default_nettype wire

// ----- design/rational_accumulator_gcd_top.sv -----
// ----------------------------------------------------------------------------
// rational_accumulator_gcd_top
// Rational accumulator: holds one reduced fraction and loads, adds or
// multiplies command words into it, reducing each result by Euclid's gcd.
// ----------------------------------------------------------------------------
// The block keeps num/den in lowest terms with den > 0; reset leaves 1/1.
// Each command word gives exactly one result word with the stored fraction
// after the step and a status (ok, bad denominator, overflow); on an error
// the stored fraction stays as it was. One word is worked on at a time and
// req.ready is low until its result is in the output register; the output
// register then holds it for the sink while the next word is taken. All
// products go through one registered 32x32 multiplier, and every remainder
// and the two final divisions by the gcd go through one shared bit-serial
// divider. Add and multiply first form their products in the multiplier;
// load skips this step. Then the Euclid remainder steps run, and the
// numerator and denominator are divided by the gcd; a zero numerator
// skips the gcd and leaves 0/1. An unused command or a bad denominator
// goes straight to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_accumulator_gcd_top (
	input  wire logic clk,
	input  wire logic arst_n,
	rag_req_if.sink   req,
	rag_rsp_if.source rsp
);

	localparam int PW = rag_pkg::PROD_W;
	localparam int MW = rag_pkg::MAG_W;
	localparam int NW = rag_pkg::NUM_W;
	localparam int DW = rag_pkg::DEN_W;

	// magnitude of a two's complement numerator; the most negative value
	// maps to 2^(NW-1) as unsigned
	function automatic logic [MW-1:0] mag(input logic [NW-1:0] v);
		mag = v[NW-1] ? MW'(~v + 1'b1) : MW'(v);
	endfunction

	rag_pkg::state_t state_q, state_d;

	// stored fraction
	logic [NW-1:0] acc_num_q;
	logic [DW-1:0] acc_den_q;

	// operands of the word at work
	rag_pkg::cmd_t cmd_q;
	logic          oneg_q, aneg_q;
	logic [MW-1:0] onm_q, odm_q, anm_q, adm_q;

	// wide working values
	logic [PW-1:0] p1_q, p2_q;
	logic [PW-1:0] nm_q, dm_q;
	logic          neg_q;
	logic [PW-1:0] a_q, b_q, g_q;
	logic          a_gt_q;
	rag_pkg::status_t st_q;

	// output register
	logic                 rsp_valid_q;
	logic [NW-1:0]        rsp_num_q;
	logic [DW-1:0]        rsp_den_q;
	rag_pkg::status_t     rsp_st_q;

	// shared units
	logic [MW-1:0]      mul_a, mul_b;
	logic [PW-1:0]      prod;
	rag_pkg::div_req_t  div_req;
	rag_pkg::div_rsp_t  div_rsp;

	// decoded input word
	logic          accept;
	logic          in_bad;
	rag_pkg::cmd_t in_cmd;

	// add step: signed magnitude sum of the two cross products; multiply passes the first product
	logic [PW-1:0] sum_mag;
	logic          sum_neg;

	// range check of the reduced fraction
	logic          ovf;
	logic          out_load;

	rag_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	rag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept = req.valid && req.ready;
	assign in_cmd = rag_pkg::cmd_t'(req.cmd);
	assign in_bad = req.operand_den[NW-1] || (req.operand_den == '0);

	always_comb begin
		if (cmd_q == rag_pkg::CMD_MUL) begin
			sum_neg = oneg_q ^ aneg_q;
			sum_mag = p1_q;
		end else if (oneg_q == aneg_q) begin
			sum_neg = oneg_q;
			sum_mag = p1_q + p2_q;
		end else if (p1_q >= p2_q) begin
			sum_neg = oneg_q;
			sum_mag = p1_q - p2_q;
		end else begin
			sum_neg = aneg_q;
			sum_mag = p2_q - p1_q;
		end
	end

	assign ovf = (dm_q > rag_pkg::LIM - 1'b1) ||
		(neg_q ? (nm_q > rag_pkg::LIM) : (nm_q > rag_pkg::LIM - 1'b1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rag_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, unit operands and handshake
	always_comb begin
		state_d          = state_q;
		req.ready        = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		out_load         = 1'b0;

		unique case (state_q)
			rag_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (in_cmd == rag_pkg::CMD_NOP || in_bad) begin
						state_d = rag_pkg::S_OUT;
					end else if (in_cmd == rag_pkg::CMD_LOAD) begin
						state_d = rag_pkg::S_COMMIT;
					end else begin
						state_d = rag_pkg::S_MUL_X;
					end
				end
			end
			rag_pkg::S_MUL_X: begin
				// first product: cross term for add, numerator for multiply
				mul_a   = onm_q;
				mul_b   = (cmd_q == rag_pkg::CMD_ADD) ? adm_q : anm_q;
				state_d = rag_pkg::S_MUL_Y;
			end
			rag_pkg::S_MUL_Y: begin
				mul_a   = anm_q;
				mul_b   = odm_q;
				state_d = rag_pkg::S_MUL_Z;
			end
			rag_pkg::S_MUL_Z: begin
				mul_a   = odm_q;
				mul_b   = adm_q;
				state_d = rag_pkg::S_MUL_W;
			end
			rag_pkg::S_MUL_W: begin
				state_d = rag_pkg::S_SUM;
			end
			rag_pkg::S_SUM: begin
				state_d = rag_pkg::S_COMMIT;
			end
			rag_pkg::S_COMMIT: begin
				if (dm_q == '0 || nm_q == '0) begin
					state_d = rag_pkg::S_OUT;
				end else begin
					state_d = rag_pkg::S_GCD;
				end
			end
			rag_pkg::S_GCD: begin
				div_req.start = 1'b1;
				if (a_q == '0 || b_q == '0) begin
					// gcd found: divide the numerator by it
					div_req.dividend = nm_q;
					div_req.divisor  = a_q | b_q;
					state_d          = rag_pkg::S_RED_N;
				end else if (a_q > b_q) begin
					div_req.dividend = a_q;
					div_req.divisor  = b_q;
					state_d          = rag_pkg::S_GCD_WAIT;
				end else begin
					div_req.dividend = b_q;
					div_req.divisor  = a_q;
					state_d          = rag_pkg::S_GCD_WAIT;
				end
			end
			rag_pkg::S_GCD_WAIT: begin
				if (div_rsp.done) begin
					state_d = rag_pkg::S_GCD;
				end
			end
			rag_pkg::S_RED_N: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = dm_q;
					div_req.divisor  = g_q;
					state_d          = rag_pkg::S_RED_D;
				end
			end
			rag_pkg::S_RED_D: begin
				if (div_rsp.done) begin
					state_d = rag_pkg::S_CHECK;
				end
			end
			rag_pkg::S_CHECK: begin
				state_d = rag_pkg::S_OUT;
			end
			rag_pkg::S_OUT: begin
				// wait for the output register to free up
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = rag_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rag_pkg::S_IDLE;
			end
		endcase
	end

	// stored fraction: reset to 1/1, update only on a clean commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_num_q <= NW'(1);
			acc_den_q <= DW'(1);
		end else if (state_q == rag_pkg::S_COMMIT && dm_q != '0 && nm_q == '0) begin
			acc_num_q <= '0;
			acc_den_q <= DW'(1);
		end else if (state_q == rag_pkg::S_CHECK && !ovf) begin
			acc_num_q <= neg_q ? (~nm_q[NW-1:0] + 1'b1) : nm_q[NW-1:0];
			acc_den_q <= dm_q[DW-1:0];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_cmd;
			oneg_q <= req.operand_num[NW-1];
			onm_q  <= mag(req.operand_num);
			odm_q  <= mag(req.operand_den);
			aneg_q <= acc_num_q[NW-1];
			anm_q  <= mag(acc_num_q);
			adm_q  <= MW'(acc_den_q);
			st_q   <= (in_cmd != rag_pkg::CMD_NOP && in_bad) ?
				rag_pkg::ST_BADDEN : rag_pkg::ST_OK;
			// load takes the operand as it is
			nm_q   <= PW'(mag(req.operand_num));
			dm_q   <= PW'(mag(req.operand_den));
			neg_q  <= req.operand_num[NW-1];
		end

		case (state_q)
			rag_pkg::S_MUL_Y: p1_q <= prod;
			rag_pkg::S_MUL_Z: p2_q <= prod;
			rag_pkg::S_MUL_W: dm_q <= prod;
			rag_pkg::S_SUM: begin
				nm_q  <= sum_mag;
				neg_q <= sum_neg;
			end
			rag_pkg::S_COMMIT: begin
				a_q <= nm_q;
				b_q <= dm_q;
				if (dm_q == '0) begin
					st_q <= rag_pkg::ST_BADDEN;
				end
			end
			rag_pkg::S_GCD: begin
				g_q    <= a_q | b_q;
				a_gt_q <= a_q > b_q;
			end
			rag_pkg::S_GCD_WAIT: begin
				// replace the larger value by the remainder
				if (div_rsp.done) begin
					if (a_gt_q) begin
						a_q <= div_rsp.rem;
					end else begin
						b_q <= div_rsp.rem;
					end
				end
			end
			rag_pkg::S_RED_N: begin
				if (div_rsp.done) begin
					nm_q <= div_rsp.quot;
				end
			end
			rag_pkg::S_RED_D: begin
				if (div_rsp.done) begin
					dm_q <= div_rsp.quot;
				end
			end
			rag_pkg::S_CHECK: begin
				if (ovf) begin
					st_q <= rag_pkg::ST_OVF;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: hold the word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_num_q <= acc_num_q;
			rsp_den_q <= acc_den_q;
			rsp_st_q  <= st_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.result_num = rsp_num_q;
	assign rsp.result_den = rsp_den_q;
	assign rsp.status     = rsp_st_q;

endmodule

`default_nettype wire

// ----- design/rag_mul.sv -----
// ----------------------------------------------------------------------------
// rag_mul
// Registered unsigned magnitude multiplier, shared by all product steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rag_mul (
	input  wire logic                         clk,
	input  wire logic [rag_pkg::MAG_W-1:0]    a,
	input  wire logic [rag_pkg::MAG_W-1:0]    b,
	output logic      [rag_pkg::PROD_W-1:0]   prod
);

	logic [rag_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= rag_pkg::PROD_W'(a) * rag_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ----- design/rag_div.sv -----
// ----------------------------------------------------------------------------
// rag_div
// Restoring radix-2 divider: one quotient bit per cycle, quotient and
// remainder valid when done pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module rag_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rag_pkg::div_req_t req,
	output rag_pkg::div_rsp_t      rsp
);

	localparam int W = rag_pkg::PROD_W;

	logic                            busy_q;
	logic                            done_q;
	logic [rag_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [W-1:0]                    rem_q;
	logic [W-1:0]                    quo_q;
	logic [W-1:0]                    den_q;

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic         qbit;
	logic [W-1:0] rem_next;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		shifted  = {rem_q, quo_q[W-1]};
		diff     = shifted - {1'b0, den_q};
		qbit     = ~diff[W];
		rem_next = qbit ? diff[W-1:0] : shifted[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= rag_pkg::DIV_CNT_W'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire
